FILE: src/assert_macros.svh
// Assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset.
`define B32_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define B32_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define B32_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define B32_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define B32_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define B32_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/b32enc_pkg.sv
// Shared types, constants and the symbol alphabet of the Base32 encoder.
package b32enc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int MAX_CHARS           = 8;

    localparam logic [6:0] PAD_CHAR    = 7'd61;  // '='
    localparam logic [6:0] ASCII_A     = 7'd65;  // 'A'
    localparam logic [6:0] ASCII_TWO   = 7'd50;  // '2'
    localparam logic [4:0] LETTER_CNT  = 5'd26;

    // One byte's worth of work: data symbols first, then padding.
    typedef struct packed {
        logic [2:0][4:0] sym;    // sym[0] goes out first
        logic [1:0]      nsym;   // data symbols, 1..3
        logic [3:0]      total;  // data symbols plus pads, 1..8
        logic            last;   // mark the final character
    } cmd_t;

    typedef struct packed {
        logic [2:0] leftover_count;
        logic [2:0] group_position;
    } front_status_t;

    function automatic logic [6:0] symbol_ascii(input logic [4:0] code);
        logic [6:0] ch;
        if (code < LETTER_CNT)
            ch = ASCII_A + {2'b00, code};
        else
            ch = ASCII_TWO + {2'b00, code - LETTER_CNT};
        return ch;
    endfunction

endpackage

FILE: src/base32_stream_encoder_top.sv
// Top level of the streaming Base32 encoder.
// Encodes a byte stream into standard Base32 ASCII characters (A-Z, 2-7), one
// character per output item; end_of_message on an input byte closes the
// message with one zero-filled partial symbol if bits remain and '=' padding
// up to a multiple of eight characters, the final character marked by
// last_symbol. The front end takes one byte per cycle while its command
// queue has room; the back end sends out one character per cycle from its
// output register while the receiver does not stall, so an ordinary byte
// yields one or two characters (8 bits make 1.6 characters on average) and a
// closing byte up to eight. That single-character output port sets the
// throughput; QUEUE_DEPTH commands buffer the difference.
`include "assert_macros.svh"

module base32_stream_encoder_top #(
    parameter int QUEUE_DEPTH = b32enc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [6:0] symbol_char,
    output logic       last_symbol,
    output logic       out_valid,
    input  logic       out_stall
);
    import b32enc_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             push_cmd;
    logic             push_valid;
    logic             q_full;
    logic             pop;
    logic             head_valid;
    cmd_t             head_cmd;
    logic [CNT_W-1:0] q_count;
    front_status_t    front_status;

    logic [2:0]       out_pos_reg, out_pos_next;
    logic             out_accept;
    logic             in_accept;
    logic             last_accept;
    logic             eom_accept;
    logic             front_clear;

    b32enc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .q_full         (q_full),
        .push_valid     (push_valid),
        .push_cmd       (push_cmd),
        .status         (front_status)
    );

    b32enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (q_count)
    );

    b32enc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .symbol_char (symbol_char),
        .last_symbol (last_symbol),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );

    assign in_accept   = in_valid && !in_stall;
    assign out_accept  = out_valid && !out_stall;
    assign last_accept = out_accept && last_symbol;
    assign eom_accept  = in_accept && end_of_message;
    assign front_clear = (front_status.leftover_count == 3'd0)
                      && (front_status.group_position == 3'd0);

    // position of the next character within its group of eight
    always_comb
    begin
        out_pos_next = out_pos_reg;
        if (out_accept)
            out_pos_next = out_pos_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_pos_reg <= 3'd0;
        else
            out_pos_reg <= out_pos_next;
    end

    `B32_ASSERT_SAME(a_last_closes_group, clk, rst_n, last_accept, out_pos_reg == 3'd7)
    `B32_ASSERT_ALWAYS(a_leftover_range, clk, rst_n, front_status.leftover_count <= 3'd4)
    `B32_ASSERT_NEXT(a_eom_clears_state, clk, rst_n, eom_accept, front_clear)
    `B32_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_count <= CNT_W'(QUEUE_DEPTH))

endmodule

FILE: src/b32enc_front.sv
// Front end: accepts bytes, splits bits into symbols and plans the padding.
module b32enc_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_message,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      q_full,
    output logic                      push_valid,
    output b32enc_pkg::cmd_t          push_cmd,
    output b32enc_pkg::front_status_t status
);
    import b32enc_pkg::*;

    logic [3:0]  leftover_bits_reg, leftover_bits_next;
    logic [2:0]  leftover_count_reg, leftover_count_next;
    logic [2:0]  group_position_reg, group_position_next;

    logic        accept;
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [3:0]  shamt;
    logic [14:0] aligned;
    logic [1:0]  nfull;
    logic [3:0]  rem_cnt;
    logic [4:0]  rem_mask;
    logic [1:0]  nsym;
    logic [2:0]  gp_after;
    logic [2:0]  npad;
    logic [3:0]  total_raw;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign push_valid = accept;

    always_comb
    begin
        acc     = {leftover_bits_reg, data_byte};
        cnt     = {1'b0, leftover_count_reg} + 4'd8;
        // top-align the valid bits; the partial symbol picks up zeros on the right
        shamt   = 4'd12 - cnt;
        aligned = {acc, 3'b000} << shamt;
        nfull   = (cnt >= 4'd10) ? 2'd2 : 2'd1;
        rem_cnt = cnt - ((nfull == 2'd2) ? 4'd10 : 4'd5);
        rem_mask = (5'd1 << rem_cnt) - 5'd1;
        nsym    = nfull + {1'b0, (end_of_message && rem_cnt != 4'd0)};
        gp_after = group_position_reg + {1'b0, nsym};
        npad    = end_of_message ? (3'd0 - gp_after) : 3'd0;
        total_raw = {2'b00, nsym} + {1'b0, npad};

        push_cmd.sym[0] = aligned[14:10];
        push_cmd.sym[1] = aligned[9:5];
        push_cmd.sym[2] = aligned[4:0];
        push_cmd.nsym   = nsym;
        push_cmd.total  = (total_raw > 4'(MAX_CHARS)) ? 4'(MAX_CHARS) : total_raw;
        push_cmd.last   = end_of_message;

        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        group_position_next = group_position_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                leftover_bits_next  = 4'd0;
                leftover_count_next = 3'd0;
                group_position_next = 3'd0;
            end
            else
            begin
                leftover_bits_next  = acc[3:0] & rem_mask[3:0];
                leftover_count_next = rem_cnt[2:0];
                group_position_next = gp_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= 4'd0;
            leftover_count_reg <= 3'd0;
            group_position_reg <= 3'd0;
        end
        else
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
            group_position_reg <= group_position_next;
        end
    end

    assign status.leftover_count = leftover_count_reg;
    assign status.group_position = group_position_reg;

endmodule

FILE: src/b32enc_queue.sv
// Short command queue between the front end and the character emitter.
module b32enc_queue #(
    parameter int DEPTH = b32enc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  b32enc_pkg::cmd_t             push_cmd,
    output logic                         full,
    input  logic                         pop,
    output logic                         head_valid,
    output b32enc_pkg::cmd_t             head_cmd,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import b32enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/b32enc_back.sv
// Back end: walks one command and emits one character per cycle while the output is not stalled.
module b32enc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  b32enc_pkg::cmd_t head_cmd,
    output logic             pop,
    output logic [6:0]       symbol_char,
    output logic             last_symbol,
    output logic             out_valid,
    input  logic             out_stall
);
    import b32enc_pkg::*;

    cmd_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;

    logic       out_free;
    logic       emit;
    logic       done;
    logic [6:0] cur_char;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = out_free && cur_valid_reg;
    assign done     = ({1'b0, idx_reg} == cur_reg.total - 4'd1);
    // fetch the next command when empty or when the current one ends now
    assign pop      = head_valid && (!cur_valid_reg || (emit && done));

    always_comb
    begin
        if ({1'b0, idx_reg} < {1'b0, cur_reg.nsym})
            cur_char = symbol_ascii(cur_reg.sym[idx_reg[1:0]]);
        else
            cur_char = PAD_CHAR;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (!cur_valid_reg || (emit && done))
        begin
            cur_valid_next = head_valid;
            cur_next       = head_cmd;
            idx_next       = 3'd0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = cur_valid_reg;
            char_next      = cur_char;
            last_next      = cur_reg.last && done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign symbol_char = char_reg;
    assign last_symbol = last_reg;

endmodule

FILE: tb/base32_stream_encoder_top_test.sv
// Self-checking testbench for the streaming Base32 encoder top level.
module base32_stream_encoder_top_test;
    import b32enc_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 24;
    localparam int PHASE_BYTES     = 44;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } b32_char_t;

    class b32_char_scoreboard;
        string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
        logic [3:0]  rem_bits = '0;
        logic [2:0]  rem_cnt  = '0;
        logic [2:0]  grp_pos  = '0;
        b32_char_t   pending_chars[$];
        int          errors   = 0;
        int          bytes_in = 0;
        int          messages = 0;
        int          chars_ok = 0;

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        // Append one accepted byte and queue the characters it produces.
        function void encode_byte(logic [7:0] data, logic eom);
            b32_char_t   fresh[MAX_CHARS];
            logic [11:0] acc;
            logic [4:0]  code;
            byte         sym;
            int          cnt;
            int          n;
            acc = {rem_bits, data};
            cnt = int'(rem_cnt) + 8;
            n   = 0;
            bytes_in++;
            while (cnt >= 5 && n < MAX_CHARS)
            begin
                code = 5'(acc >> (cnt - 5));
                sym = alphabet[code];
                fresh[n] = '{sym[6:0], 1'b0};
                n++;
                cnt -= 5;
                grp_pos++;
            end
            if (!eom)
            begin
                rem_bits = 4'(acc & ((12'd1 << cnt) - 12'd1));
                rem_cnt  = 3'(cnt);
            end
            else
            begin
                // zero-fill the remaining bits on the right
                if (cnt > 0 && cnt < 5 && n < MAX_CHARS)
                begin
                    code = 5'((acc & ((12'd1 << cnt) - 12'd1)) << (5 - cnt));
                    sym = alphabet[code];
                    fresh[n] = '{sym[6:0], 1'b0};
                    n++;
                    grp_pos++;
                end
                while (grp_pos != 3'd0 && n < MAX_CHARS)
                begin
                    fresh[n] = '{PAD_CHAR, 1'b0};
                    n++;
                    grp_pos++;
                end
                if (n > 0)
                    fresh[n - 1].last = 1'b1;
                rem_bits = '0;
                rem_cnt  = '0;
                grp_pos  = '0;
                messages++;
            end
            for (int k = 0; k < n; k++)
                pending_chars.push_back(fresh[k]);
        endfunction

        task match_char(logic [6:0] ch, logic last);
            b32_char_t want;
            if (pending_chars.size() == 0)
                report($sformatf("unexpected char %0d last %0b", ch, last));
            else
            begin
                want = pending_chars.pop_front();
                chars_ok++;
                if (ch !== want.ch)
                    report($sformatf("symbol_char got %0d want %0d", ch, want.ch));
                if (last !== want.last)
                    report($sformatf("last_symbol got %0b want %0b (char %0d)",
                                     last, want.last, want.ch));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       end_of_message;
    logic       in_valid;
    logic       in_stall;
    logic [6:0] symbol_char;
    logic       last_symbol;
    logic       out_valid;
    logic       out_stall;

    b32_char_scoreboard chars;
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_off_req  = 1'b0;
    int  quiet_cycles  = 0;

    logic [7:0] corner_bytes[16] = '{
        8'h00, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F,
        8'hFE, 8'h0F, 8'hF0, 8'h00, 8'hFF, 8'h84, 8'h21, 8'hC6
    };

    base32_stream_encoder_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol_char    (symbol_char),
        .last_symbol    (last_symbol),
        .out_valid      (out_valid),
        .out_stall      (out_stall)
    );

    always #5 clk = ~clk;

    // Offer one item after a random gap and hold it until it is taken.
    task automatic send_byte(input logic [7:0] data, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        data_byte      <= data;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic run_phase(input int idle_pct, input int stalls, input bit hold_off);
        int sent;
        int len;
        send_idle_pct = idle_pct;
        stall_pct     = stalls;
        sent          = 0;
        if (hold_off)
            hold_off_req = 1'b1;
        while (sent < PHASE_BYTES)
        begin
            len = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
                send_byte(8'($urandom_range(255)), k == len - 1);
            sent += len;
        end
    endtask

    // Receiver: random stall, with one long hold-off on request.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Note input items before checking output items of the same edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                chars.encode_byte(data_byte, end_of_message);
            if (out_valid && !out_stall)
                chars.match_char(symbol_char, last_symbol);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int idx;
        chars = new();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        end_of_message <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Message lengths 1..6 reach every leftover count at the end.
        idx = 0;
        for (int len = 1; len <= 6; len++)
        begin
            for (int k = 0; k < len; k++)
            begin
                send_byte(corner_bytes[idx % 16], k == len - 1);
                idx++;
            end
        end

        run_phase(0, 0, 1'b1);
        run_phase(75, 0, 1'b0);
        run_phase(0, 75, 1'b0);
        run_phase(36, 36, 1'b0);
        in_valid <= 1'b0;

        while (chars.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chars.pending_chars.size() != 0)
            chars.report($sformatf("%0d chars never arrived", chars.pending_chars.size()));

        $display("Encoded %0d bytes in %0d messages, %0d characters compared,",
                 chars.bytes_in, chars.messages, chars.chars_ok);
        $display("under no idling, sender gaps, receiver stalls, both, and a long hold-off.");
        if (chars.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/b32enc_pkg.sv
src/b32enc_front.sv
src/b32enc_queue.sv
src/b32enc_back.sv
src/base32_stream_encoder_top.sv
tb/base32_stream_encoder_top_test.sv
